[sv/mm_pkg.sv]
// Shared types and constants for the matrix multiply block.
// Used by the controller, the datapath, the top level and the checker.
package mm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int IDX_W       = 3;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 4;
  localparam int CFG_IW      = 2;
  localparam int CFG_N       = 4;
  localparam int PROD_W      = 48;
  localparam int ACC_W       = 52;

  localparam logic [1:0] CMD_WR_A    = 2'd0;
  localparam logic [1:0] CMD_WR_B    = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_IW-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_IW-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_IW-1:0] REG_B_COLS = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             first;
    logic             last_term;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] t;
    logic             load_out;
    logic             load_err;
    logic             out_last;
  } mm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } mm_stat_t;

endpackage

[sv/mm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/mm_ctrl.sv]
// Controller of the matrix multiply block: configuration registers, input
// handshake and the sequencer over rows, columns and terms. Uses mm_pkg.
module mm_ctrl #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_command,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mm_pkg::CNT_W-1:0]  cfg_data,
  output mm_pkg::mm_cmd_t           cmd,
  input  mm_pkg::mm_stat_t          stat
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PUSH  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  localparam logic [mm_pkg::CNT_W-1:0] MAXC = mm_pkg::CNT_W'(MAX_DIM);
  localparam logic [mm_pkg::CNT_W-1:0] ONE  = mm_pkg::CNT_W'(1);

  logic [2:0] state_r, state_nxt;
  logic [mm_pkg::CNT_W-1:0] cnt_r [mm_pkg::CFG_N];
  logic [mm_pkg::CNT_W-1:0] m_r, m_nxt, n_r, n_nxt, k_r, k_nxt;
  logic [mm_pkg::IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, t_r, t_nxt;
  logic [mm_pkg::CNT_W-1:0] m_use, k_use, kb_use, n_use;
  logic accept, t_last, i_last, j_last;

  // A count of zero acts as one, and a count above the array size as the size.
  function automatic logic [mm_pkg::CNT_W-1:0] used_count(
    input logic [mm_pkg::CNT_W-1:0] v
  );
    logic [mm_pkg::CNT_W-1:0] r;
    if (v == '0) begin
      r = ONE;
    end else if (v > MAXC) begin
      r = MAXC;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;

  assign m_use  = used_count(cnt_r[mm_pkg::REG_A_ROWS]);
  assign k_use  = used_count(cnt_r[mm_pkg::REG_A_COLS]);
  assign kb_use = used_count(cnt_r[mm_pkg::REG_B_ROWS]);
  assign n_use  = used_count(cnt_r[mm_pkg::REG_B_COLS]);

  assign t_last = ({1'b0, t_r} == k_r - ONE);
  assign i_last = ({1'b0, i_r} == m_r - ONE);
  assign j_last = ({1'b0, j_r} == n_r - ONE);

  always_comb begin
    state_nxt = state_r;
    m_nxt = m_r;
    n_nxt = n_r;
    k_nxt = k_r;
    i_nxt = i_r;
    j_nxt = j_r;
    t_nxt = t_r;
    cmd = '0;
    cmd.wr_a = accept && (in_command == mm_pkg::CMD_WR_A);
    cmd.wr_b = accept && (in_command == mm_pkg::CMD_WR_B);
    cmd.i = i_r;
    cmd.j = j_r;
    cmd.t = t_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == mm_pkg::CMD_COMPUTE)) begin
          if (k_use != kb_use) begin
            state_nxt = ST_ERR;
          end else begin
            m_nxt = m_use;
            n_nxt = n_use;
            k_nxt = k_use;
            i_nxt = '0;
            j_nxt = '0;
            t_nxt = '0;
            state_nxt = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        cmd.first = (t_r == '0);
        cmd.last_term = t_last;
        if (t_last) begin
          t_nxt = '0;
          state_nxt = ST_DRAIN;
        end else begin
          t_nxt = t_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (stat.acc_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = i_last && j_last;
          if (i_last && j_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MAC;
            if (j_last) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.load_err = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int r = 0; r < mm_pkg::CFG_N; r++) begin
        cnt_r[r] <= mm_pkg::CNT_W'(8);
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cnt_r[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    n_r <= n_nxt;
    k_r <= k_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    t_r <= t_nxt;
  end

endmodule

[sv/mm_dp.sv]
// Datapath of the matrix multiply block: the A and B stores, the Q16.16
// multiplier, the accumulator, saturation and the output register.
// Uses mm_pkg and mm_ram.
module mm_dp #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mm_pkg::IDX_W-1:0]  in_row_index,
  input  logic [mm_pkg::IDX_W-1:0]  in_col_index,
  input  logic [mm_pkg::VAL_W-1:0]  in_element_value,
  input  mm_pkg::mm_cmd_t           cmd,
  output mm_pkg::mm_stat_t          stat,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mm_pkg::IDX_W-1:0]  out_row,
  output logic [mm_pkg::IDX_W-1:0]  out_col,
  output logic [mm_pkg::VAL_W-1:0]  out_value,
  output logic                      out_size_error,
  output logic                      out_last_item
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VW    = mm_pkg::VAL_W;
  localparam int PW    = mm_pkg::PROD_W;
  localparam int CW    = mm_pkg::ACC_W;

  logic [AW-1:0] waddr, a_raddr, b_raddr;
  logic in_range;
  logic [VW-1:0] a_rd, b_rd;
  logic signed [2*VW-1:0] full_prod;
  logic signed [PW-1:0] prod_r;
  logic signed [CW-1:0] acc_r, acc_nxt;
  logic rd_v_r, rd_first_r, rd_last_r;
  logic mul_v_r, mul_first_r, mul_last_r;
  logic acc_done_r;
  logic [VW-1:0] sat_val;
  logic out_valid_r;
  logic [mm_pkg::IDX_W-1:0] out_row_r, out_col_r;
  logic [VW-1:0] out_value_r;
  logic out_err_r, out_last_r;

  // Writes outside the array are dropped.
  assign in_range = ({1'b0, in_row_index} < 4'(MAX_DIM))
                 && ({1'b0, in_col_index} < 4'(MAX_DIM));
  assign waddr   = AW'(int'(in_row_index) * MAX_DIM + int'(in_col_index));
  assign a_raddr = AW'(int'(cmd.i) * MAX_DIM + int'(cmd.t));
  assign b_raddr = AW'(int'(cmd.t) * MAX_DIM + int'(cmd.j));

  mm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (cmd.wr_a && in_range),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  mm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (cmd.wr_b && in_range),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  assign full_prod = $signed(a_rd) * $signed(b_rd);

  assign acc_nxt = mul_first_r ? CW'(prod_r) : acc_r + CW'(prod_r);

  // The accumulator fits in 32 bits when its top bits are all copies of bit 31.
  always_comb begin
    if ((&acc_r[CW-1:VW-1]) || !(|acc_r[CW-1:VW-1])) begin
      sat_val = acc_r[VW-1:0];
    end else if (acc_r[CW-1]) begin
      sat_val = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      acc_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r     <= cmd.issue;
      mul_v_r    <= rd_v_r;
      acc_done_r <= mul_v_r && mul_last_r;
      if (cmd.load_out || cmd.load_err) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r  <= cmd.first;
    rd_last_r   <= cmd.last_term;
    mul_first_r <= rd_first_r;
    mul_last_r  <= rd_last_r;
    prod_r      <= full_prod[2*VW-1:16];
    if (mul_v_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.load_out) begin
      out_row_r   <= cmd.i;
      out_col_r   <= cmd.j;
      out_value_r <= sat_val;
      out_err_r   <= 1'b0;
      out_last_r  <= cmd.out_last;
    end else if (cmd.load_err) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_value_r <= '0;
      out_err_r   <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign stat.acc_done = acc_done_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_value      = out_value_r;
  assign out_size_error = out_err_r;
  assign out_last_item  = out_last_r;

endmodule

[sv/matrix_multiply_top.sv]
// Matrix multiply block, C = A x B on signed Q16.16 values.
// Top level joining mm_ctrl and mm_dp; uses mm_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): each item is an element write to A
//   or B, or a compute command. Writes are taken one per cycle while the block
//   is idle and give no result. A compute command is taken while the block is
//   idle, even while an earlier result still waits in the output register.
//   Result channel (out_valid / out_stall): one item per C element in
//   row-major order, the last one flagged by out_last_item. If A's used column
//   count differs from B's used row count, a single item with out_size_error and
//   out_last_item set is given instead.
//   Configuration (cfg_valid / cfg_ready): the four dimension counts, to be
//   written only while the block is idle, which the block does not enforce;
//   cfg_ready is always high.
// Operation: each C element takes K reads of the store ports (K the used count),
//   passed through the read, product and accumulator registers, then a load
//   of the output register; a compute run holds the input channel throughout.
// A stalled receiver holds the current result and pauses the sequencer.
// Reset clears the control state and sets all counts to 8; the stores are
// not cleared and must be written before they are used.
module matrix_multiply_top #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_command,
  input  logic [mm_pkg::IDX_W-1:0]  in_row_index,
  input  logic [mm_pkg::IDX_W-1:0]  in_col_index,
  input  logic [mm_pkg::VAL_W-1:0]  in_element_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mm_pkg::IDX_W-1:0]  out_row,
  output logic [mm_pkg::IDX_W-1:0]  out_col,
  output logic [mm_pkg::VAL_W-1:0]  out_value,
  output logic                      out_size_error,
  output logic                      out_last_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mm_pkg::CNT_W-1:0]  cfg_data
);

  mm_pkg::mm_cmd_t  cmd;
  mm_pkg::mm_stat_t stat;

  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat)
  );

  mm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_size_error   (out_size_error),
    .out_last_item    (out_last_item)
  );

endmodule

[sv/mm_check.sv]
// Port-level checker for the matrix multiply block, bound to the top level.
// Uses mm_pkg.
module mm_check (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                in_command,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [mm_pkg::IDX_W-1:0]  out_row,
  input logic [mm_pkg::IDX_W-1:0]  out_col,
  input logic [mm_pkg::VAL_W-1:0]  out_value,
  input logic                      out_size_error,
  input logic                      out_last_item
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value)
      && $stable(out_row) && $stable(out_col) && $stable(out_last_item))
    else $error("stalled result changed");

  // An error result is the only and last item of its run, with zero fields.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_size_error |-> out_last_item && (out_value == '0)
      && (out_row == '0) && (out_col == '0))
    else $error("malformed size error result");

  // A compute command occupies the block.
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == mm_pkg::CMD_COMPUTE) |=> in_stall)
    else $error("block idle right after a compute command");

  // Writes and unused commands leave the block ready for the next item.
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command != mm_pkg::CMD_COMPUTE) |=> !in_stall)
    else $error("block busy after a write");

endmodule

bind matrix_multiply_top mm_check u_mm_check (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for matrix_multiply_top (C = A x B, signed Q16.16).
// Predicts every product element from its own copy of the stores and counts;
// depends on mm_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
  import mm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DIM = MAX_DIM_DEF;
  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             size_error;
    logic             last_item;
  } c_elem_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_command;
  logic [IDX_W-1:0]    in_row_index;
  logic [IDX_W-1:0]    in_col_index;
  logic [VAL_W-1:0]    in_element_value;
  logic                out_valid;
  logic                out_stall;
  logic [IDX_W-1:0]    out_row;
  logic [IDX_W-1:0]    out_col;
  logic [VAL_W-1:0]    out_value;
  logic                out_size_error;
  logic                out_last_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CNT_W-1:0]    cfg_data;

  // Shadow state of the block.
  logic [VAL_W-1:0] a_mem [DIM][DIM];
  logic [VAL_W-1:0] b_mem [DIM][DIM];
  logic [CNT_W-1:0] dim_reg [CFG_N];

  c_elem_t pending_elems [$];
  int      error_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  matrix_multiply_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_size_error   (out_size_error),
    .out_last_item    (out_last_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // A count of zero acts as one, anything above the store size as the maximum.
  function automatic int dim_used(input logic [CNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM) return DIM;
    return int'(raw);
  endfunction

  function automatic void predict_product();
    int m, k, kb, n;
    logic signed [63:0] acc, pa, pb;
    c_elem_t e;
    m  = dim_used(dim_reg[REG_A_ROWS]);
    k  = dim_used(dim_reg[REG_A_COLS]);
    kb = dim_used(dim_reg[REG_B_ROWS]);
    n  = dim_used(dim_reg[REG_B_COLS]);
    if (k != kb) begin
      e = '{row: '0, col: '0, value: '0, size_error: 1'b1, last_item: 1'b1};
      pending_elems.push_back(e);
      return;
    end
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int t = 0; t < k; t++) begin
          pa = 64'($signed(a_mem[i][t]));
          pb = 64'($signed(b_mem[t][j]));
          // Arithmetic shift floors each product toward minus infinity.
          acc = acc + ((pa * pb) >>> 16);
        end
        e.row = IDX_W'(i);
        e.col = IDX_W'(j);
        if (acc > Q_MAX) e.value = 32'h7FFF_FFFF;
        else if (acc < Q_MIN) e.value = 32'h8000_0000;
        else e.value = acc[31:0];
        e.size_error = 1'b0;
        e.last_item  = (i == m - 1) && (j == n - 1);
        pending_elems.push_back(e);
      end
    end
  endfunction

  function automatic void apply_item(input logic [1:0] cmd, input logic [IDX_W-1:0] row,
                                     input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
    case (cmd)
      CMD_WR_A:    a_mem[row][col] = val;
      CMD_WR_B:    b_mem[row][col] = val;
      CMD_COMPUTE: predict_product();
      default: ;
    endcase
  endfunction

  // Mix of extremes, full-range values and values small enough not to saturate.
  function automatic logic [VAL_W-1:0] rand_q16();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0001_0000;
      endcase
    end
    if (sel <= 2) return $urandom;
    if (sel <= 5) return $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
    return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_row_index     <= row;
    in_col_index     <= col;
    in_element_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_item(cmd, row, col, val);
  endtask

  // Holds the sender back until every expected element has come out.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_elems.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_dim(input logic [CFG_IW-1:0] idx, input logic [CNT_W-1:0] value);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    dim_reg[idx] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_dims(input logic [CNT_W-1:0] a_rows, input logic [CNT_W-1:0] a_cols,
                          input logic [CNT_W-1:0] b_rows, input logic [CNT_W-1:0] b_cols);
    write_dim(REG_A_ROWS, a_rows);
    write_dim(REG_A_COLS, a_cols);
    write_dim(REG_B_ROWS, b_rows);
    write_dim(REG_B_COLS, b_cols);
  endtask

  function automatic logic [CNT_W-1:0] rand_count();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return CNT_W'($urandom_range(15, 9));
    return CNT_W'($urandom_range(DIM, 1));
  endfunction

  task automatic set_random_dims();
    logic [CNT_W-1:0] a_cols, b_rows;
    int k;
    a_cols = rand_count();
    k = dim_used(a_cols);
    if ($urandom_range(4) == 0) b_rows = rand_count();
    else if (k == 1) b_rows = CNT_W'($urandom_range(1));
    else if (k == DIM) b_rows = CNT_W'($urandom_range(15, DIM));
    else b_rows = CNT_W'(k);
    set_dims(rand_count(), a_cols, b_rows, rand_count());
  endtask

  // Fill both stores completely, then multiply at the counts left by reset.
  task automatic test_reset_dims();
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        send_item(CMD_WR_A, IDX_W'(r), IDX_W'(c), rand_q16());
        send_item(CMD_WR_B, IDX_W'(c), IDX_W'(r), rand_q16());
      end
    end
    send_item(CMD_COMPUTE, '0, '0, '0);
  endtask

  task automatic test_saturation();
    wait_idle();
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    send_item(CMD_WR_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(CMD_WR_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(CMD_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_WR_B, 3'd0, 3'd0, 32'h8000_0000);
    send_item(CMD_COMPUTE, '0, '0, '0);
    send_item(CMD_WR_A, 3'd0, 3'd0, 32'h8000_0000);
    send_item(CMD_COMPUTE, '0, '0, '0);
  endtask

  task automatic test_rounding();
    // The smallest positive value times minus one lsb must floor to -1 lsb.
    send_item(CMD_WR_A, 3'd0, 3'd0, 32'h0000_0001);
    send_item(CMD_WR_B, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send_item(CMD_COMPUTE, '0, '0, '0);
    send_item(CMD_WR_A, 3'd0, 3'd0, 32'hFFFF_0000);
    send_item(CMD_WR_B, 3'd0, 3'd0, 32'h0001_8000);
    send_item(CMD_COMPUTE, '0, '0, '0);
  endtask

  task automatic test_ignored_command();
    send_item(CMD_WR_A, 3'd7, 3'd7, 32'h7FFF_FFFF);
    send_item(CMD_WR_B, 3'd7, 3'd7, 32'h8000_0000);
    send_item(CMD_UNUSED, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(CMD_COMPUTE, '0, '0, '0);
  endtask

  task automatic test_size_error();
    wait_idle();
    set_dims(4'd1, 4'd2, 4'd1, 4'd1);
    send_item(CMD_COMPUTE, '0, '0, '0);
    wait_idle();
    set_dims(4'd15, 4'd0, 4'd15, 4'd0);
    send_item(CMD_COMPUTE, '0, '0, '0);
  endtask

  task automatic test_random_phases();
    int sel;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      // One phase pins the counts to out-of-range values that still match.
      if (ph == 1) set_dims(4'd0, 4'd15, 4'd9, 4'd0);
      else set_random_dims();
      for (int n = 0; n < 45; n++) begin
        sel = $urandom_range(99);
        if (sel < 42) begin
          send_item(CMD_WR_A, IDX_W'($urandom), IDX_W'($urandom), rand_q16());
        end else if (sel < 84) begin
          send_item(CMD_WR_B, IDX_W'($urandom), IDX_W'($urandom), rand_q16());
        end else if (sel < 93) begin
          send_item(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
          if ($urandom_range(7) == 0) wait_idle();
        end else begin
          send_item(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    c_elem_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_elems.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual row %0d col %0d value %h",
                 $time, out_row, out_col, out_value);
        error_count++;
      end else begin
        want = pending_elems.pop_front();
        if (out_row !== want.row)
          report_mismatch("out_row", VAL_W'(want.row), VAL_W'(out_row));
        if (out_col !== want.col)
          report_mismatch("out_col", VAL_W'(want.col), VAL_W'(out_col));
        if (out_value !== want.value) report_mismatch("out_value", want.value, out_value);
        if (out_size_error !== want.size_error)
          report_mismatch("size_error", VAL_W'(want.size_error), VAL_W'(out_size_error));
        if (out_last_item !== want.last_item)
          report_mismatch("last_item", VAL_W'(want.last_item), VAL_W'(out_last_item));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("** matrix_multiply_top: FAILED **");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_WR_A;
    in_row_index     = '0;
    in_col_index     = '0;
    in_element_value = '0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_A_ROWS;
    cfg_data         = '0;
    for (int r = 0; r < CFG_N; r++) dim_reg[r] = CNT_W'(DIM);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_dims();
    test_saturation();
    test_rounding();
    test_ignored_command();
    test_size_error();
    test_random_phases();

    wait_idle();
    repeat (30) @(posedge clk);
    if (error_count == 0 && pending_elems.size() == 0) begin
      $display("** matrix_multiply_top: PASSED **");
    end else begin
      $display("** matrix_multiply_top: FAILED **");
    end
    $finish;
  end

endmodule
